@@ rtl/gdsc_pkg.sv @@
package gdsc_pkg;

  localparam int COV_W      = 8;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PROD_W     = 2 * COV_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_RED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_BLUE    = 3'd4;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 10'd64;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd16;
  localparam logic [COV_W-1:0]    COLOR_RST  = 8'd255;

  typedef logic [COV_W-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } color_t;

  typedef struct packed {
    chan_t t;
    chan_t s;
    logic  frame_end;
  } pix_t;

  // exact floor(x / 255) for x below 65280
  function automatic chan_t div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {{(COV_W+1){1'b0}}, x[PROD_W-1:COV_W]} + {{PROD_W{1'b0}}, 1'b1};
    return sum[PROD_W-1:COV_W];
  endfunction

endpackage

@@ rtl/gdsc_if.sv @@
interface gdsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coverage;

  modport source (output valid, output coverage, input ready);
  modport sink   (input valid, input coverage, output ready);
endinterface

interface gdsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic [7:0] alpha_out;
  logic       frame_end;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output alpha_out, output frame_end, input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  input alpha_out, input frame_end, output ready);
endinterface

@@ rtl/gdsc_line_store.sv @@
module gdsc_line_store #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  gdsc_pkg::chan_t                 coverage,
  input  logic [gdsc_pkg::WIDTH_W-1:0]    width_cfg,
  input  logic [gdsc_pkg::HEIGHT_W-1:0]   height_cfg,
  output gdsc_pkg::pix_t                  pix
);
  import gdsc_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int EW0   = $clog2(MAX_WIDTH + 1);
  localparam int EW    = (EW0 > WIDTH_W) ? EW0 : WIDTH_W;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

  chan_t              mem [MAX_WIDTH];
  chan_t              diag_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;

  logic [EW-1:0]       w_cfg;
  logic [EW-1:0]       w_eff;
  logic [EW-1:0]       col_inc;
  logic [HEIGHT_W-1:0] h_eff;
  logic [HEIGHT_W-1:0] row_inc;
  logic                last_col;
  logic                last_row;

  always_comb begin
    w_cfg = EW'(width_cfg);
    if (w_cfg == '0) begin
      w_eff = EW'(1);
    end else if (w_cfg > MAX_W) begin
      w_eff = MAX_W;
    end else begin
      w_eff = w_cfg;
    end
    if (height_cfg == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (height_cfg > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end else begin
      h_eff = height_cfg;
    end
  end

  assign col_inc  = EW'(col_r) + EW'(1);
  assign row_inc  = HEIGHT_W'(row_r) + HEIGHT_W'(1);
  assign last_col = col_inc >= w_eff;
  assign last_row = row_inc >= h_eff;

  // read-before-write: diag_r keeps the prior row's value for the next column's pixel
  always_ff @(posedge clk) begin
    if (accept) begin
      diag_r     <= mem[col_r];
      mem[col_r] <= coverage;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  assign pix.t         = coverage;
  assign pix.s         = (col_r == '0 || row_r == '0) ? '0 : diag_r;
  assign pix.frame_end = last_col && last_row;

endmodule

@@ rtl/gdsc_blend.sv @@
module gdsc_blend (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gdsc_pkg::pix_t   pix,
  input  gdsc_pkg::color_t color,
  gdsc_out_if.source       out_pix
);
  import gdsc_pkg::*;

  logic   a_valid_r;
  pix_t   a_pix_r;
  color_t a_color_r;

  logic              b_valid_r;
  pix_t              b_pix_r;
  color_t            b_color_r;
  logic [PROD_W-1:0] b_red_p_r;
  logic [PROD_W-1:0] b_green_p_r;
  logic [PROD_W-1:0] b_blue_p_r;
  logic [PROD_W-1:0] b_alpha_p_r;

  logic  o_valid_r;
  chan_t o_blue_r;
  chan_t o_green_r;
  chan_t o_red_r;
  chan_t o_alpha_r;
  logic  o_end_r;

  logic  adv_o;
  logic  adv_b;
  logic  adv_a;
  chan_t blue_nxt;
  chan_t green_nxt;
  chan_t red_nxt;
  chan_t alpha_nxt;

  assign adv_o    = !o_valid_r || out_pix.ready;
  assign adv_b    = !b_valid_r || adv_o;
  assign adv_a    = !a_valid_r || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (adv_a) a_valid_r <= in_valid;
      if (adv_b) b_valid_r <= a_valid_r;
      if (adv_o) o_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_pix_r   <= pix;
      a_color_r <= color;
    end
    if (adv_b && a_valid_r) begin
      b_pix_r     <= a_pix_r;
      b_color_r   <= a_color_r;
      b_red_p_r   <= a_color_r.red * a_pix_r.t;
      b_green_p_r <= a_color_r.green * a_pix_r.t;
      b_blue_p_r  <= a_color_r.blue * a_pix_r.t;
      b_alpha_p_r <= (8'd255 - a_pix_r.t) * a_pix_r.s;
    end
    if (adv_o && b_valid_r) begin
      o_blue_r  <= blue_nxt;
      o_green_r <= green_nxt;
      o_red_r   <= red_nxt;
      o_alpha_r <= alpha_nxt;
      o_end_r   <= b_pix_r.frame_end;
    end
  end

  always_comb begin
    blue_nxt  = b_color_r.blue;
    green_nxt = b_color_r.green;
    red_nxt   = b_color_r.red;
    alpha_nxt = b_pix_r.t;
    if (b_pix_r.t == '0) begin
      if (b_pix_r.s != '0) begin
        blue_nxt  = '0;
        green_nxt = '0;
        red_nxt   = '0;
        alpha_nxt = b_pix_r.s;
      end
    end else if (b_pix_r.s != '0) begin
      blue_nxt  = div255(b_blue_p_r);
      green_nxt = div255(b_green_p_r);
      red_nxt   = div255(b_red_p_r);
      alpha_nxt = b_pix_r.t + div255(b_alpha_p_r);
    end
  end

  assign out_pix.valid     = o_valid_r;
  assign out_pix.blue_out  = o_blue_r;
  assign out_pix.green_out = o_green_r;
  assign out_pix.red_out   = o_red_r;
  assign out_pix.alpha_out = o_alpha_r;
  assign out_pix.frame_end = o_end_r;

endmodule

@@ rtl/glyph_drop_shadow_compositor_unit.sv @@
// Each input transfer moves through the blend's a, b and output registers.
// Throughput: one pixel per cycle unless stalled, bounded by the line store's
// single read-modify-write access per pixel (one read, one write at the same column).
// Reset (synchronous, rst_n low): counters, pipeline valids and config registers
// return to defaults; the line store is not cleared and needs no clearing pass.
module glyph_drop_shadow_compositor_unit #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gdsc_in_if.sink                           in_pix,
  gdsc_out_if.source                        out_pix,
  input  logic                              cfg_we,
  input  logic [gdsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gdsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gdsc_pkg::*;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  color_t              color_r;
  pix_t                ls_pix;
  logic                in_ready;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= WIDTH_RST;
      height_r      <= HEIGHT_RST;
      color_r.red   <= COLOR_RST;
      color_r.green <= COLOR_RST;
      color_r.blue  <= COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r       <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_r      <= cfg_data[HEIGHT_W-1:0];
        REG_FONT_RED:     color_r.red   <= cfg_data[COV_W-1:0];
        REG_FONT_GREEN:   color_r.green <= cfg_data[COV_W-1:0];
        REG_FONT_BLUE:    color_r.blue  <= cfg_data[COV_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.ready = in_ready;
  assign accept       = in_pix.valid && in_ready;

  gdsc_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .coverage   (in_pix.coverage),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .pix        (ls_pix)
  );

  gdsc_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pix.valid),
    .in_ready (in_ready),
    .pix      (ls_pix),
    .color    (color_r),
    .out_pix  (out_pix)
  );

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("pipeline not empty after reset");

  a_first_pixel_no_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> ls_pix.s == '0)
    else $error("shadow source nonzero on first pixel of frame");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.ready |-> in_ready)
    else $error("input stalled while output side is ready");

endmodule

@@ tb/sv/gdsc_checker.sv @@
`timescale 1ns / 1ps

module gdsc_checker
  import gdsc_pkg::*;
#(
  parameter int LINE_MAX = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gdsc_in_if                    in_mon,
  gdsc_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    chan_t alpha;
    logic  frame_end;
  } bgra_px_t;

  logic [WIDTH_W-1:0]  frame_w;
  logic [HEIGHT_W-1:0] frame_h;
  color_t              font;
  chan_t               line_mem [LINE_MAX];
  chan_t               diag;
  int unsigned         col;
  int unsigned         row;
  bgra_px_t            pending_px [$];
  int                  results_seen;

  function automatic bgra_px_t composite_next(input chan_t cov);
    int unsigned w, h, t, s, c;
    bgra_px_t    px;
    logic        last_col, last_row;
    w = (frame_w == 0) ? 1 : ((frame_w > LINE_MAX) ? LINE_MAX : frame_w);
    h = (frame_h == 0) ? 1 : ((frame_h > MAX_HEIGHT) ? MAX_HEIGHT : frame_h);
    t = cov;
    c = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
    s = (col == 0 || row == 0) ? 0 : diag;
    diag = line_mem[c];
    line_mem[c] = cov;
    if (s == 0) begin
      px.blue  = font.blue;
      px.green = font.green;
      px.red   = font.red;
      px.alpha = chan_t'(t);
    end else if (t == 0) begin
      px.blue  = '0;
      px.green = '0;
      px.red   = '0;
      px.alpha = chan_t'(s);
    end else begin
      px.blue  = chan_t'(font.blue * t / 255);
      px.green = chan_t'(font.green * t / 255);
      px.red   = chan_t'(font.red * t / 255);
      px.alpha = chan_t'(t + (255 - t) * s / 255);
    end
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    px.frame_end = last_col && last_row;
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
    return px;
  endfunction

  always @(posedge clk) begin : watch
    bgra_px_t got, want;
    if (!rst_n) begin
      frame_w = WIDTH_RST;
      frame_h = HEIGHT_RST;
      font    = {COLOR_RST, COLOR_RST, COLOR_RST};
      diag    = '0;
      col     = 0;
      row     = 0;
      pending_px.delete();
      foreach (line_mem[i]) line_mem[i] = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.blue_out, out_mon.green_out, out_mon.red_out,
               out_mon.alpha_out, out_mon.frame_end};
        results_seen++;
        if (pending_px.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d with no pixel pending: bgra %0d/%0d/%0d/%0d end %0b",
                     results_seen, got.blue, got.green, got.red, got.alpha, got.frame_end);
        end else begin
          want = pending_px.pop_front();
          if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
              got.alpha !== want.alpha || got.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result %0d: expected bgra %0d/%0d/%0d/%0d end %0b, got %0d/%0d/%0d/%0d end %0b",
                       results_seen, want.blue, want.green, want.red, want.alpha,
                       want.frame_end, got.blue, got.green, got.red, got.alpha,
                       got.frame_end);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w    = cfg_data[WIDTH_W-1:0];
          REG_FRAME_HEIGHT: frame_h    = cfg_data[HEIGHT_W-1:0];
          REG_FONT_RED:     font.red   = cfg_data[COV_W-1:0];
          REG_FONT_GREEN:   font.green = cfg_data[COV_W-1:0];
          REG_FONT_BLUE:    font.blue  = cfg_data[COV_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        pending_px.push_back(composite_next(in_mon.coverage));
    end
  end

endmodule

@@ tb/sv/tb_glyph_drop_shadow_compositor_unit.sv @@
`timescale 1ns / 1ps

module tb_glyph_drop_shadow_compositor_unit;
  import gdsc_pkg::*;

  localparam int LINE_MAX  = 512;
  localparam int WAIT_MAX  = 18;
  localparam int QUIET_MAX = 2000;
  localparam int SETTLE    = 12;
  localparam int ITEM_GOAL = 1300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  localparam chan_t RESET_RUN [4]   = '{8'd0, 8'd255, 8'd1, 8'd128};
  localparam chan_t SHADOW_4X3 [12] = '{8'd0, 8'd0,   8'd0, 8'd0,
                                        8'd0, 8'd255, 8'd1, 8'd0,
                                        8'd0, 8'd0,   8'd0, 8'd255};
  localparam chan_t TINY_2X2 [4]    = '{8'd9, 8'd0, 8'd0, 8'd200};

  typedef struct {
    int w;
    int h;
    int pixels;
  } geo_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int sent;
  int received;
  int phases;
  int quiet;
  int geo_w;
  int geo_h;
  bit in_calm;
  bit out_calm;

  gdsc_in_if  in_pix ();
  gdsc_out_if out_pix ();

  glyph_drop_shadow_compositor_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_pix   (out_pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gdsc_checker #(.LINE_MAX(LINE_MAX)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_pix),
    .out_mon    (out_pix),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches)
  );

  always #5 clk = ~clk;

  function automatic int clamp_dim(input int raw, input int top);
    return (raw == 0) ? 1 : ((raw > top) ? top : raw);
  endfunction

  function automatic chan_t pick_cov();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'd0;
      4:          return 8'd255;
      5:          return 8'd1;
      default:    return chan_t'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic push_pixel(input chan_t cov);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, WAIT_MAX);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.coverage <= cov;
    do @(posedge clk); while (!in_pix.ready);
    sent++;
  endtask

  // all results back before the next register write
  task automatic begin_phase();
    in_pix.valid <= 1'b0;
    while (received != sent) @(posedge clk);
    phases++;
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
  endtask

  // bits above the register width carry junk
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int bits);
    logic [CFG_DATA_W-1:0] d, mask;
    mask = (CFG_DATA_W'(1) << bits) - 1'b1;
    d    = CFG_DATA_W'($urandom);
    d    = (d & ~mask) | (CFG_DATA_W'(value) & mask);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(REG_FRAME_WIDTH, w, WIDTH_W);
    write_reg(REG_FRAME_HEIGHT, h, HEIGHT_W);
    geo_w = clamp_dim(w, LINE_MAX);
    geo_h = clamp_dim(h, int'(MAX_HEIGHT));
  endtask

  task automatic set_colors(input int red, input int green, input int blue);
    write_reg(REG_FONT_RED, red, COV_W);
    write_reg(REG_FONT_GREEN, green, COV_W);
    write_reg(REG_FONT_BLUE, blue, COV_W);
  endtask

  task automatic send_frame(input bit padded);
    for (int r = 0; r < geo_h; r++)
      for (int c = 0; c < geo_w; c++) begin
        if (padded && (r == 0 || c == 0 || r == geo_h - 1 || c == geo_w - 1))
          push_pixel(8'd0);
        else
          push_pixel(pick_cov());
      end
  endtask

  initial begin : result_sink
    int stall;
    out_pix.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, WAIT_MAX);
      if (stall > 0) begin
        out_pix.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pix.ready <= 1'b1;
      do @(posedge clk); while (!out_pix.valid);
      received++;
    end
  end

  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_pix.valid && out_pix.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("timeout: no transfer for %0d cycles, %0d sent, %0d received",
               quiet, sent, received);
      $display("tb_glyph_drop_shadow_compositor_unit: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    geo_step_t geo_steps [6];
    int        w, h;
    geo_steps = '{'{20, 5, 30}, '{6, 5, 19}, '{1, 8191, 20},
                  '{1, 3, 1}, '{4, 4, 6}, '{10, 4, 27}};
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_pix.valid    <= 1'b0;
    in_pix.coverage <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset colors, then end the frame early by shrinking it
    foreach (RESET_RUN[i]) push_pixel(RESET_RUN[i]);
    begin_phase();
    set_geometry(3, 1);
    cfg_we <= 1'b0;
    push_pixel(8'd0);

    begin_phase();
    set_geometry(4, 3);
    set_colors(200, 0, 255);
    cfg_we <= 1'b0;
    foreach (SHADOW_4X3[i]) push_pixel(SHADOW_4X3[i]);

    // unused indexes must not disturb anything; zero width and height act as one
    begin_phase();
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(CFG_IDX_W'(i), 0, 0);
    set_geometry(0, 0);
    cfg_we <= 1'b0;
    push_pixel(8'd255);
    push_pixel(8'd0);

    begin_phase();
    set_geometry(2, 2);
    set_colors(0, 0, 0);
    cfg_we <= 1'b0;
    foreach (TINY_2X2[i]) push_pixel(TINY_2X2[i]);

    // oversize width clamps to the full line; fills every line store entry
    begin_phase();
    set_geometry(1023, 1);
    set_colors(pick_level(), pick_level(), pick_level());
    cfg_we <= 1'b0;
    send_frame(1'b0);

    // geometry rewritten mid-frame, counters carry over
    foreach (geo_steps[i]) begin
      begin_phase();
      set_geometry(geo_steps[i].w, geo_steps[i].h);
      cfg_we <= 1'b0;
      repeat (geo_steps[i].pixels) push_pixel(pick_cov());
    end

    while (sent < ITEM_GOAL) begin
      begin_phase();
      if ($urandom_range(0, 7) == 0)
        write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)), 0, 0);
      set_colors(pick_level(), pick_level(), pick_level());
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 2);
          h = $urandom_range(3, 6);
        end
        1: begin
          w = $urandom_range(3, 12);
          h = $urandom_range(0, 2);
        end
        2: begin
          w = $urandom_range(17, 40);
          h = $urandom_range(3, 4);
        end
        default: begin
          w = $urandom_range(3, 16);
          h = $urandom_range(3, 8);
        end
      endcase
      set_geometry(w, h);
      cfg_we <= 1'b0;
      repeat ($urandom_range(1, 2)) send_frame($urandom_range(0, 2) != 0);
    end

    in_pix.valid <= 1'b0;
    while (received != sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("summary: %0d pixels sent, %0d results taken over %0d config phases",
             sent, received, phases);
    $display("summary: reset colors, width/height clamps, unused indexes, full line, "
             , "mid-frame geometry rewrites, random padded and unpadded frames");
    if (mismatches == 0)
      $display("tb_glyph_drop_shadow_compositor_unit: done, clean");
    else
      $display("tb_glyph_drop_shadow_compositor_unit: done, errors");
    $finish;
  end

endmodule
